### src/duplex_fallthrough_byte_fifo_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the duplex fall-through byte FIFO
// Shared shorthands for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DUPLEX_FALLTHROUGH_BYTE_FIFO_MACROS_SVH
`define DUPLEX_FALLTHROUGH_BYTE_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFBF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfbf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DFBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfbf assertion failed");

`endif

### src/dfbf_pkg.sv
// ----------------------------------------------------------------------------
// dfbf_pkg
// Shared types and constants of the duplex fall-through byte FIFO.
// ----------------------------------------------------------------------------
package dfbf_pkg;

  localparam int DEPTH_DEFAULT      = 256;
  localparam int WORD_BYTES_DEFAULT = 2;

  // Operation codes of an input word.
  localparam logic [1:0] OP_LOGIC     = 2'd0;
  localparam logic [1:0] OP_HOST_PUSH = 2'd1;
  localparam logic [1:0] OP_HOST_POP  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic        logic_write;
    logic        logic_advance;
    logic        clear_overrun;
    logic        clear_underrun;
    logic [15:0] logic_word_in;
    logic [7:0]  host_byte_in;
  } dfbf_in_t;

  typedef struct packed {
    logic [15:0] logic_word_out;
    logic        out_readable;
    logic        out_above_one_word;
    logic        in_writable;
    logic        in_room_beyond_word;
    logic        overrun_flag;
    logic        underrun_flag;
    logic [7:0]  host_byte_out;
    logic        host_ok;
  } dfbf_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic push;
    logic rd0;
    logic rd1;
    logic finish;
  } dfbf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic push_go;
    logic push_last;
    logic slot_free;
  } dfbf_status_t;

endpackage

### src/dfbf_ram.sv
// ----------------------------------------------------------------------------
// dfbf_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module dfbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/dfbf_ctrl.sv
// ----------------------------------------------------------------------------
// dfbf_ctrl
// Sequencer of the FIFO bridge: accept, execute, byte pushes, head reads,
// and hand-off to the output register.
// ----------------------------------------------------------------------------
`include "duplex_fallthrough_byte_fifo_macros.svh"

module dfbf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dfbf_pkg::dfbf_status_t status,
  output dfbf_pkg::dfbf_cmd_t    cmd
);
  import dfbf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_PUSH = 6'b000100,
    ST_RD0  = 6'b001000,
    ST_RD1  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.push_go ? ST_PUSH : ST_RD0;
      end
      ST_PUSH: begin
        if (status.push_last) state_next = ST_RD0;
      end
      ST_RD0: begin
        state_next = ST_RD1;
      end
      ST_RD1: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready   = (state == ST_IDLE);
  assign cmd.accept = in_valid && (state == ST_IDLE);
  assign cmd.exec   = (state == ST_EXEC);
  assign cmd.push   = (state == ST_PUSH);
  assign cmd.rd0    = (state == ST_RD0);
  assign cmd.rd1    = (state == ST_RD1);
  assign cmd.finish = (state == ST_DONE) && status.slot_free;

  `DFBF_ASSERT_NEXT(a_accept_busy, clk, rst, cmd.accept, !in_ready && cmd.exec)
  `DFBF_ASSERT_NEXT(a_rd0_rd1, clk, rst, cmd.rd0, cmd.rd1)

endmodule

### src/dfbf_datapath.sv
// ----------------------------------------------------------------------------
// dfbf_datapath
// Ring pointers, fill counts, sticky flags, the two byte RAMs and the
// output register of the FIFO bridge.
// ----------------------------------------------------------------------------
`include "duplex_fallthrough_byte_fifo_macros.svh"

module dfbf_datapath #(
  parameter int DEPTH      = dfbf_pkg::DEPTH_DEFAULT,
  parameter int WORD_BYTES = dfbf_pkg::WORD_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dfbf_pkg::dfbf_cmd_t    cmd,
  output dfbf_pkg::dfbf_status_t status,
  input  dfbf_pkg::dfbf_in_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dfbf_pkg::dfbf_out_t    out_data
);
  import dfbf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(WORD_BYTES + 1);
  localparam int SUM_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  dfbf_in_t          item;
  logic [PTR_W-1:0]  in_head;
  logic [PTR_W-1:0]  in_tail;
  logic [CNT_W-1:0]  in_count;
  logic [PTR_W-1:0]  out_head;
  logic [PTR_W-1:0]  out_tail;
  logic [CNT_W-1:0]  out_count;
  logic              overrun;
  logic              underrun;
  logic              pop_ok;
  logic              host_ok;
  logic [IDX_W-1:0]  push_idx;
  logic [7:0]        byte0;

  logic              is_logic;
  logic              in_full;
  logic              out_full;
  logic              host_push_ok;
  logic              host_pop_ok;
  logic              adv_req;
  logic [SUM_W-1:0]  adv_n;
  logic [SUM_W-1:0]  adv_sum;
  logic [PTR_W-1:0]  adv_tail;
  logic [7:0]        push_byte;
  logic [7:0]        in_rdata;
  logic [7:0]        out_rdata;
  logic              present0;
  logic              present1;
  dfbf_out_t         result;

  assign is_logic     = (item.op == OP_LOGIC);
  assign in_full      = (in_count == CNT_W'(DEPTH));
  assign out_full     = (out_count == CNT_W'(DEPTH));
  assign host_push_ok = (item.op == OP_HOST_PUSH) && !out_full;
  assign host_pop_ok  = (item.op == OP_HOST_POP) && (in_count != '0);
  assign adv_req      = is_logic && item.logic_advance;

  // The advance is clamped to the fill; the sum stays below twice the depth.
  assign adv_n    = (SUM_W'(WORD_BYTES) < SUM_W'(out_count)) ? SUM_W'(WORD_BYTES)
                                                            : SUM_W'(out_count);
  assign adv_sum  = SUM_W'(out_tail) + adv_n;
  assign adv_tail = (adv_sum >= SUM_W'(DEPTH)) ? PTR_W'(adv_sum - SUM_W'(DEPTH))
                                               : PTR_W'(adv_sum);

  // Bytes above the 16-bit logic word are pushed as zero.
  always_comb begin
    if (push_idx == IDX_W'(0)) begin
      push_byte = item.logic_word_in[7:0];
    end else if (push_idx == IDX_W'(1)) begin
      push_byte = item.logic_word_in[15:8];
    end else begin
      push_byte = 8'h00;
    end
  end

  assign status.push_go   = is_logic && item.logic_write && !in_full;
  assign status.push_last = (SUM_W'(push_idx) + SUM_W'(1) == SUM_W'(WORD_BYTES)) ||
                            (in_count + CNT_W'(1) == CNT_W'(DEPTH));
  assign status.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.rd1) begin
      byte0 <= out_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_head   <= '0;
      in_tail   <= '0;
      in_count  <= '0;
      out_head  <= '0;
      out_tail  <= '0;
      out_count <= '0;
      overrun   <= 1'b0;
      underrun  <= 1'b0;
      pop_ok    <= 1'b0;
      host_ok   <= 1'b0;
      push_idx  <= '0;
    end else begin
      if (cmd.accept) begin
        push_idx <= '0;
      end
      if (cmd.exec) begin
        pop_ok  <= host_pop_ok;
        host_ok <= host_push_ok || host_pop_ok;
        if (is_logic && item.clear_overrun) overrun <= 1'b0;
        if (is_logic && item.clear_underrun) underrun <= 1'b0;
        if (is_logic && item.logic_write && in_full) overrun <= 1'b1;
        if (adv_req) begin
          if (out_count == '0) begin
            underrun <= 1'b1;
          end else begin
            out_tail  <= adv_tail;
            out_count <= out_count - CNT_W'(adv_n);
          end
        end
        if (host_push_ok) begin
          out_head  <= wrap_inc(out_head);
          out_count <= out_count + CNT_W'(1);
        end
        if (host_pop_ok) begin
          in_tail  <= wrap_inc(in_tail);
          in_count <= in_count - CNT_W'(1);
        end
      end
      if (cmd.push) begin
        in_head  <= wrap_inc(in_head);
        in_count <= in_count + CNT_W'(1);
        push_idx <= push_idx + IDX_W'(1);
      end
    end
  end

  dfbf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_in_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (in_head),
    .wdata (push_byte),
    .re    (cmd.exec && host_pop_ok),
    .raddr (in_tail),
    .rdata (in_rdata)
  );

  dfbf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_out_ram (
    .clk   (clk),
    .we    (cmd.exec && host_push_ok),
    .waddr (out_head),
    .wdata (item.host_byte_in),
    .re    (cmd.rd0 || cmd.rd1),
    .raddr (cmd.rd1 ? wrap_inc(out_tail) : out_tail),
    .rdata (out_rdata)
  );

  assign present0 = (out_count != '0);
  assign present1 = (WORD_BYTES >= 2) && (out_count >= CNT_W'(2));

  always_comb begin
    result.logic_word_out      = {(present1 ? out_rdata : 8'h00),
                                  (present0 ? byte0 : 8'h00)};
    result.out_readable        = present0;
    result.out_above_one_word  = SUM_W'(out_count) > SUM_W'(WORD_BYTES);
    result.in_writable         = !in_full;
    result.in_room_beyond_word = (SUM_W'(in_count) + SUM_W'(WORD_BYTES)) < SUM_W'(DEPTH);
    result.overrun_flag        = overrun;
    result.underrun_flag       = underrun;
    result.host_byte_out       = pop_ok ? in_rdata : 8'h00;
    result.host_ok             = host_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= result;
    end
  end

  `DFBF_ASSERT_NOW(a_in_count_range, clk, rst, 1'b1, in_count <= CNT_W'(DEPTH))
  `DFBF_ASSERT_NEXT(a_push_grows, clk, rst, cmd.push, in_count == $past(in_count) + CNT_W'(1))
  `DFBF_ASSERT_NOW(a_finish_free, clk, rst, cmd.finish, !out_valid || out_ready)

endmodule

### src/duplex_fallthrough_byte_fifo.sv
// ----------------------------------------------------------------------------
// duplex_fallthrough_byte_fifo
// Two byte rings bridging a word-wide logic side and a byte-wide host side,
// with first-word fall-through of the outbound head and almost flags.
// ----------------------------------------------------------------------------
// Usage: every input word on the in channel carries one operation: a logic
// step (clear sticky flags, push a word inbound, advance one word outbound),
// a host byte push into the outbound ring, or a host byte pop from the
// inbound ring. Every input word yields exactly one output word on the out
// channel, holding the outbound head word, the ring flags, the sticky flags
// and the host byte result.
// The sequencer takes a word, executes it, writes the bytes a logic push
// stores (none up to WORD_BYTES) one by one, reads the two head bytes and
// passes the result to the output register; only then is a new word taken.
// Each ring RAM has one write port and one registered read port: pushed bytes
// are written in turn, and the outbound head bytes are read in turn.
// The output register frees the input side: the next word is taken while a
// result still waits. If the receiver stalls, the block holds its finished
// result in the sequencer until the output register is free.
// Reset empties both rings and clears the sticky flags; ring contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module duplex_fallthrough_byte_fifo #(
  parameter int DEPTH      = dfbf_pkg::DEPTH_DEFAULT,
  parameter int WORD_BYTES = dfbf_pkg::WORD_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dfbf_pkg::dfbf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dfbf_pkg::dfbf_out_t out_data
);
  import dfbf_pkg::*;

  dfbf_cmd_t    cmd;
  dfbf_status_t status;

  // The sequencer only steps through phases; all ring and flag state lives in the datapath.
  dfbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dfbf_datapath #(
    .DEPTH      (DEPTH),
    .WORD_BYTES (WORD_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### test/tb_duplex_fallthrough_byte_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_duplex_fallthrough_byte_fifo
// Self-checking bench for the duplex fall-through byte FIFO. A queue of
// operation words, filled up front with a short directed run and then with
// phases that fill and drain each ring, feeds a valid/ready driver. Every
// accepted word is run through a bench-side copy of both rings, and each
// status word that leaves the block is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_duplex_fallthrough_byte_fifo;
  import dfbf_pkg::*;

  localparam int          RING      = DEPTH_DEFAULT;
  localparam int          WB        = WORD_BYTES_DEFAULT;
  localparam int          IDLE_PCT  = 29;
  localparam int          QUIET_MAX = 2000;
  // The block takes op 3 as a no-op that only reports status; the package has no name for it.
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  typedef enum {PH_FILL_IN, PH_DRAIN_IN, PH_FILL_OUT, PH_DRAIN_OUT, PH_MIX} phase_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  dfbf_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  dfbf_out_t out_data;

  duplex_fallthrough_byte_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Words waiting to be offered, and status words predicted but not yet seen.
  dfbf_in_t  op_queue[$];
  dfbf_out_t status_due[$];

  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned quiet_cycles  = 0;
  logic        in_taken      = 1'b0;

  // Bench-side copy of the two rings and the sticky flags.
  logic [7:0]  inb_mem [0:RING-1];
  logic [7:0]  outb_mem[0:RING-1];
  int unsigned inb_wr = 0, inb_rd = 0, inb_fill = 0;
  int unsigned outb_wr = 0, outb_rd = 0, outb_fill = 0;
  logic        overrun_seen = 1'b0, underrun_seen = 1'b0;

  // A stretch in the middle of the run in which neither side ever idles, so
  // the block also sees back-to-back words and an always-ready receiver.
  wire in_calm  = (words_sent >= 300) && (words_sent < 400);
  wire out_calm = (words_checked >= 300) && (words_checked < 400);

  // Apply one operation word to the ring copies and return the status word
  // the block must produce for it.
  task automatic bridge_step(input dfbf_in_t w, output dfbf_out_t r);
    int unsigned n;
    r = '0;
    case (w.op)
      OP_LOGIC: begin
        // Clears act first, so a push or advance in the same step can set
        // the flag again.
        if (w.clear_overrun) overrun_seen = 1'b0;
        if (w.clear_underrun) underrun_seen = 1'b0;
        if (w.logic_write) begin
          if (inb_fill >= RING) begin
            overrun_seen = 1'b1;
          end else begin
            // A nearly full ring takes what fits and silently drops the rest.
            for (int i = 0; i < WB && inb_fill < RING; i++) begin
              inb_mem[inb_wr] = w.logic_word_in[8*i +: 8];
              inb_wr = (inb_wr + 1) % RING;
              inb_fill++;
            end
          end
        end
        if (w.logic_advance) begin
          if (outb_fill == 0) begin
            underrun_seen = 1'b1;
          end else begin
            n = (outb_fill < WB) ? outb_fill : WB;
            outb_rd = (outb_rd + n) % RING;
            outb_fill -= n;
          end
        end
      end
      OP_HOST_PUSH: begin
        if (outb_fill < RING) begin
          outb_mem[outb_wr] = w.host_byte_in;
          outb_wr = (outb_wr + 1) % RING;
          outb_fill++;
          r.host_ok = 1'b1;
        end
      end
      OP_HOST_POP: begin
        if (inb_fill != 0) begin
          r.host_byte_out = inb_mem[inb_rd];
          inb_rd = (inb_rd + 1) % RING;
          inb_fill--;
          r.host_ok = 1'b1;
        end
      end
      default: ;
    endcase
    // Fall-through head word: only the bytes actually held, the rest zero.
    n = (outb_fill < WB) ? outb_fill : WB;
    for (int i = 0; i < n; i++)
      r.logic_word_out[8*i +: 8] = outb_mem[(outb_rd + i) % RING];
    r.out_readable        = (outb_fill != 0);
    r.out_above_one_word  = (outb_fill > WB);
    r.in_writable         = (inb_fill != RING);
    r.in_room_beyond_word = (inb_fill + WB < RING);
    r.overrun_flag        = overrun_seen;
    r.underrun_flag       = underrun_seen;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  function automatic dfbf_in_t op_word(input logic [1:0] op, input logic wr,
                                       input logic adv, input logic clr_ovr,
                                       input logic clr_udr, input logic [15:0] word,
                                       input logic [7:0] host_byte);
    dfbf_in_t w;
    w.op             = op;
    w.logic_write    = wr;
    w.logic_advance  = adv;
    w.clear_overrun  = clr_ovr;
    w.clear_underrun = clr_udr;
    w.logic_word_in  = word;
    w.host_byte_in   = host_byte;
    return w;
  endfunction

  // Queue a run of words biased toward one ring activity. The payload and
  // the fields a host step ignores are always random.
  task automatic add_phase(input phase_t kind, input int len, input int pct);
    dfbf_in_t w;
    for (int k = 0; k < len; k++) begin
      w = op_word(OP_LOGIC, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(7) == 0, $urandom_range(7) == 0,
                  16'($urandom), 8'($urandom));
      case (kind)
        PH_FILL_IN: begin
          w.logic_write   = ($urandom_range(99) < pct);
          w.logic_advance = ($urandom_range(9) == 0);
        end
        PH_DRAIN_IN:  if ($urandom_range(99) < pct) w.op = OP_HOST_POP;
        PH_FILL_OUT:  if ($urandom_range(99) < pct) w.op = OP_HOST_PUSH;
        PH_DRAIN_OUT: begin
          w.logic_advance = ($urandom_range(99) < pct);
          w.logic_write   = ($urandom_range(9) == 0);
        end
        default: w.op = 2'($urandom_range(3));
      endcase
      op_queue.push_back(w);
    end
  endtask

  // Driver: a new word is offered only when the line is free or the word on
  // it was taken at the last rising edge, so valid never drops early.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (op_queue.size() != 0 && (in_calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= op_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls at random, except inside the calm stretch.
  always @(negedge clk) begin
    out_ready <= !rst && (out_calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Monitor and predictor. The outgoing word is checked before the incoming
  // one is predicted, so a status word that arrives with nothing due is
  // always caught.
  always @(posedge clk) begin
    dfbf_out_t want, got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        words_checked++;
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: status word 0x%0h with nothing expected", $time, got);
        end else begin
          want = status_due.pop_front();
          check_field("logic_word_out", want.logic_word_out, got.logic_word_out);
          check_field("out_readable", want.out_readable, got.out_readable);
          check_field("out_above_one_word", want.out_above_one_word,
                      got.out_above_one_word);
          check_field("in_writable", want.in_writable, got.in_writable);
          check_field("in_room_beyond_word", want.in_room_beyond_word,
                      got.in_room_beyond_word);
          check_field("overrun_flag", want.overrun_flag, got.overrun_flag);
          check_field("underrun_flag", want.underrun_flag, got.underrun_flag);
          check_field("host_byte_out", want.host_byte_out, got.host_byte_out);
          check_field("host_ok", want.host_ok, got.host_ok);
        end
      end
      if (in_valid && in_ready) begin
        bridge_step(in_data, want);
        status_due.push_back(want);
        words_sent++;
      end
      in_taken <= in_valid && in_ready;
    end
  end

  // Watchdog: a long run of cycles with no word moving on either side
  // means the block has hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    // Directed opening: unused op and host pop on an empty ring, underrun
    // and its clear, extreme words both ways, full and clamped advances,
    // then push and advance in the same logic step.
    op_queue.push_back(op_word(OP_UNUSED,    1, 1, 1, 1, 16'hFFFF, 8'hFF));
    op_queue.push_back(op_word(OP_HOST_POP,  1, 1, 1, 1, 16'hFFFF, 8'hFF));
    op_queue.push_back(op_word(OP_LOGIC,     0, 1, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_LOGIC,     1, 0, 0, 1, 16'hFFFF, 8'h00));
    op_queue.push_back(op_word(OP_LOGIC,     1, 0, 0, 0, 16'h0000, 8'hFF));
    op_queue.push_back(op_word(OP_LOGIC,     1, 0, 1, 0, 16'hA55A, 8'h00));
    op_queue.push_back(op_word(OP_HOST_POP,  0, 0, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_HOST_POP,  1, 1, 1, 1, 16'hFFFF, 8'hFF));
    op_queue.push_back(op_word(OP_HOST_POP,  0, 0, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_HOST_PUSH, 0, 0, 0, 0, 16'h0000, 8'hFF));
    op_queue.push_back(op_word(OP_HOST_PUSH, 1, 1, 1, 1, 16'hFFFF, 8'h00));
    op_queue.push_back(op_word(OP_HOST_PUSH, 0, 0, 0, 0, 16'h0000, 8'h5A));
    op_queue.push_back(op_word(OP_LOGIC,     0, 1, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_LOGIC,     0, 1, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_LOGIC,     0, 1, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_LOGIC,     0, 0, 1, 1, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_HOST_PUSH, 0, 0, 0, 0, 16'h0000, 8'h01));
    op_queue.push_back(op_word(OP_LOGIC,     1, 1, 0, 0, 16'h8001, 8'h00));
    op_queue.push_back(op_word(OP_UNUSED,    0, 0, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_HOST_POP,  0, 0, 0, 0, 16'h0000, 8'h00));
    op_queue.push_back(op_word(OP_HOST_POP,  0, 0, 0, 0, 16'h0000, 8'h00));

    // Fill the inbound ring past full so overrun fires, open a gap of three
    // bytes and push again so a later word only half fits. Then run the
    // outbound ring full and drain it again.
    add_phase(PH_FILL_IN,   150, 94);
    add_phase(PH_DRAIN_IN,    3, 100);
    add_phase(PH_FILL_IN,     4, 100);
    add_phase(PH_FILL_OUT,  262, 100);
    add_phase(PH_DRAIN_OUT, 135, 95);
    // Random phases with random content for the rest.
    while (op_queue.size() < 725)
      add_phase(phase_t'($urandom_range(4)), $urandom_range(20, 80), 90);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid || status_due.size() != 0)
      @(posedge clk);
    // Let any stray status word show up before deciding.
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/dfbf_pkg.sv
src/dfbf_ram.sv
src/dfbf_ctrl.sv
src/dfbf_datapath.sv
src/duplex_fallthrough_byte_fifo.sv
test/tb_duplex_fallthrough_byte_fifo.sv
